// ----- rtl/cobs_enc_pkg.sv -----
// Shared types and constants for the COBS frame encoder.
`default_nettype none

package cobs_enc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 255;
    localparam int unsigned MAX_RESULTS     = 4;
    localparam int unsigned CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] RUN_FULL   = 8'hFF;
    localparam logic [7:0] DELIM_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [8:0] write_addr;
        logic [7:0] write_value;
        logic       is_delimiter;
        logic [8:0] frame_length;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [8:0] write_pos;
        logic [8:0] code_pos;
        logic [7:0] run_code;
        logic [7:0] byte_count;
    } enc_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic                            frame_end;
        out_item_t [MAX_RESULTS-1:0]     slot;
    } step_out_t;

endpackage

`default_nettype wire

// ----- rtl/cobs_frame_encoder_core.sv -----
// Top level of the COBS frame encoder: handshakes, state and result queue.
`default_nettype none

// Usage:
//   Input channel (in_valid / in_stall / in_item): one raw frame byte per
//   item, last_byte set on the final byte. A frame is cut after 255 bytes.
//   Output channel (out_valid / out_stall / out_item): addressed byte writes
//   into the encoded frame buffer; data bytes, code bytes, then a 0x00
//   delimiter that carries the frame length. run_last marks the final write
//   caused by one input item.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes the pause bit;
//   always ready, write only while idle. While paused, bytes still advance
//   the encoder state but produce no writes.
// Timing:
//   An item's first write appears in the cycle after it is accepted. An
//   item causing k writes (1 to 4) holds the output until all k leave; a
//   new item is taken in the cycle its predecessor's last write leaves, so
//   plain data bytes stream at one item per cycle unless the receiver stalls.
// Reset: clears the pause bit, the frame state and the result queue.
// Stall: when the receiver stalls, the pending write holds and the input
//   stalls while any write is queued, unless the last one leaves that cycle.
module cobs_frame_encoder_core (
    input  var logic                   clk,
    input  var logic                   rst_n,
    input  var logic                   in_valid,
    output logic                       in_stall,
    input  var cobs_enc_pkg::in_item_t in_item,
    output logic                       out_valid,
    input  var logic                   out_stall,
    output cobs_enc_pkg::out_item_t    out_item,
    input  var logic                   cfg_valid,
    output logic                       cfg_ready,
    input  var logic                   cfg_data
);
    import cobs_enc_pkg::*;

    logic             paused_reg;
    enc_state_t       state_reg;
    enc_state_t       state_next;
    step_out_t        step;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    out_item_t        slot_reg  [MAX_RESULTS];
    out_item_t        slot_next [MAX_RESULTS];
    logic             in_take;
    logic             out_take;

    cobs_enc_step u_step (
        .state      (state_reg),
        .item       (in_item),
        .state_next (state_next),
        .step       (step)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = (cnt_reg != '0);
    assign out_item  = slot_reg[0];
    assign out_take  = out_valid && !out_stall;
    // Room for a new item once the queue is empty or its last entry leaves now.
    assign in_stall  = !((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_take));
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (in_take)
        begin
            // paused: state still advances, nothing is queued
            cnt_next = paused_reg ? '0 : step.count;
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_next[i] = step.slot[i];
            end
        end
        else if (out_take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg           <= 1'b0;
            cnt_reg              <= '0;
            state_reg.write_pos  <= 9'd1;
            state_reg.code_pos   <= 9'd0;
            state_reg.run_code   <= 8'd1;
            state_reg.byte_count <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                paused_reg <= cfg_data;
            end
            cnt_reg <= cnt_next;
            if (in_take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_RESULTS)
        else $error("result queue count out of range");

    a_unpaused_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !paused_reg) |=> out_valid)
        else $error("accepted byte produced no write");

    a_delim_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.is_delimiter) |-> out_item.run_last)
        else $error("delimiter is not the last write of its byte");

    a_length_only_delim: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.is_delimiter) |-> (out_item.frame_length == 9'd0))
        else $error("frame length on a non-delimiter write");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && step.frame_end) |=>
            (state_reg.write_pos == 9'd1) && (state_reg.byte_count == 8'd0))
        else $error("state not restarted after frame end");
`endif

endmodule

`default_nettype wire

// ----- rtl/cobs_enc_step.sv -----
// Per-byte encoding step: next state and the writes one byte causes.
`default_nettype none

module cobs_enc_step (
    input  var cobs_enc_pkg::enc_state_t state,
    input  var cobs_enc_pkg::in_item_t   item,
    output cobs_enc_pkg::enc_state_t     state_next,
    output cobs_enc_pkg::step_out_t      step
);
    import cobs_enc_pkg::*;

    logic [7:0] count_inc;
    logic       frame_end;
    logic       is_zero;
    logic       run_full;
    logic [7:0] run_inc;
    logic [8:0] wp_1;
    logic [8:0] wp_2;
    logic [8:0] pos_mid;   // write position after data/run handling
    logic [8:0] code_mid;
    logic [7:0] run_mid;
    out_item_t  first_wr;
    out_item_t  full_wr;
    out_item_t  code_wr;
    out_item_t  delim_wr;

    always_comb
    begin
        count_inc = state.byte_count + 8'd1;
        frame_end = item.last_byte || (32'(count_inc) >= MAX_FRAME_BYTES);
        is_zero   = (item.data_byte == 8'd0);
        run_inc   = state.run_code + 8'd1;
        run_full  = !is_zero && (run_inc == RUN_FULL);
        wp_1      = state.write_pos + 9'd1;
        wp_2      = state.write_pos + 9'd2;

        first_wr = '0;
        full_wr  = '0;
        code_wr  = '0;
        delim_wr = '0;

        if (is_zero)
        begin
            first_wr.write_addr  = state.code_pos;
            first_wr.write_value = state.run_code;
            code_mid             = state.write_pos;
            pos_mid              = wp_1;
            run_mid              = 8'd1;
        end
        else
        begin
            first_wr.write_addr  = state.write_pos;
            first_wr.write_value = item.data_byte;
            if (run_full)
            begin
                code_mid = wp_1;
                pos_mid  = wp_2;
                run_mid  = 8'd1;
            end
            else
            begin
                code_mid = state.code_pos;
                pos_mid  = wp_1;
                run_mid  = run_inc;
            end
        end

        full_wr.write_addr  = state.code_pos;
        full_wr.write_value = RUN_FULL;

        code_wr.write_addr  = code_mid;
        code_wr.write_value = run_mid;

        delim_wr.write_addr   = pos_mid;
        delim_wr.write_value  = DELIM_BYTE;
        delim_wr.is_delimiter = 1'b1;
        delim_wr.frame_length = pos_mid + 9'd1;
        delim_wr.run_last     = 1'b1;

        step.frame_end = frame_end;
        step.slot      = '0;
        step.slot[0]   = first_wr;
        if (run_full)
        begin
            step.slot[1] = full_wr;
            step.slot[2] = code_wr;
            step.slot[3] = delim_wr;
        end
        else
        begin
            step.slot[1] = code_wr;
            step.slot[2] = delim_wr;
        end

        if (frame_end)
        begin
            step.count = run_full ? CNT_W'(4) : CNT_W'(3);
        end
        else if (run_full)
        begin
            step.count          = CNT_W'(2);
            step.slot[1].run_last = 1'b1;
        end
        else
        begin
            step.count          = CNT_W'(1);
            step.slot[0].run_last = 1'b1;
        end

        if (frame_end)
        begin
            state_next.write_pos  = 9'd1;
            state_next.code_pos   = 9'd0;
            state_next.run_code   = 8'd1;
            state_next.byte_count = 8'd0;
        end
        else
        begin
            state_next.write_pos  = pos_mid;
            state_next.code_pos   = code_mid;
            state_next.run_code   = run_mid;
            state_next.byte_count = count_inc;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for cobs_frame_encoder_core: directed table, then random frames vs a local encoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cobs_enc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 7;
    localparam int DIR_ROWS    = 21;
    localparam int RAND_ITEMS  = 470;
    localparam int IDLE_PAD    = 12;      // idle margin before a pause write
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_LIMIT = 20000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 40;

    // What the directed table does to the pause register before a row's item.
    typedef enum logic [1:0] {
        CFG_KEEP,
        CFG_PAUSE,
        CFG_RESUME
    } cfg_op_e;

    // One directed row: exp_n == 0 means the local encoder supplies the writes.
    typedef struct packed {
        cfg_op_e              op;
        in_item_t             item;
        logic [2:0]           exp_n;
        out_item_t [2:0]      exp;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    cobs_frame_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Encoder state as the block should hold it, plus our copy of the pause bit.
    logic [8:0] enc_write_pos;
    logic [8:0] enc_code_pos;
    logic [7:0] enc_run_code;
    logic [7:0] enc_byte_cnt;
    logic       enc_paused;

    out_item_t exp_writes[$];   // buffer writes still owed by the block, oldest first
    in_item_t  frame_q[$];      // bytes of the frame being fed in the random part
    dir_row_t  dir_tab[DIR_ROWS];

    int err_cnt;
    int cycle_cnt;
    int rand_sent;
    int long_done;
    int long_left;              // bytes of a long frame not yet sent
    bit gaps_on;
    bit hold_req;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic out_item_t mk_write(logic [8:0] addr, logic [7:0] val, logic delim,
                                           logic [8:0] len, logic rl);
        out_item_t w;
        w.write_addr   = addr;
        w.write_value  = val;
        w.is_delimiter = delim;
        w.frame_length = len;
        w.run_last     = rl;
        return w;
    endfunction

    function automatic dir_row_t mk_row(cfg_op_e op, logic [7:0] d, logic l);
        dir_row_t row;
        row                = '0;
        row.op             = op;
        row.item.data_byte = d;
        row.item.last_byte = l;
        return row;
    endfunction

    // Row whose writes are typed in; only used from the just-reset frame state.
    function automatic dir_row_t mk_typed(logic [7:0] d, logic l, logic [2:0] n,
                                          out_item_t e0, out_item_t e1, out_item_t e2);
        dir_row_t row;
        row       = mk_row(CFG_KEEP, d, l);
        row.exp_n = n;
        row.exp[0] = e0;
        row.exp[1] = e1;
        row.exp[2] = e2;
        return row;
    endfunction

    // Advance the encoder by one raw byte and, unless paused, queue its writes.
    // keep == 0 advances state only (the caller supplies the writes).
    function automatic void encode_byte(input in_item_t it, input bit keep);
        out_item_t w [4];
        int        n;
        logic      eof;
        n   = 0;
        eof = it.last_byte;
        enc_byte_cnt = enc_byte_cnt + 8'd1;
        // frame cap: the 255th byte closes the frame whatever its flag says
        if (enc_byte_cnt >= MAX_FRAME_BYTES)
            eof = 1'b1;
        if (it.data_byte == DELIM_BYTE) begin
            // zero byte closes the run: its code goes to the reserved slot
            w[n] = mk_write(enc_code_pos, enc_run_code, 1'b0, 9'd0, 1'b0);
            n++;
            enc_code_pos  = enc_write_pos;
            enc_write_pos = enc_write_pos + 9'd1;
            enc_run_code  = 8'd1;
        end else begin
            w[n] = mk_write(enc_write_pos, it.data_byte, 1'b0, 9'd0, 1'b0);
            n++;
            enc_write_pos = enc_write_pos + 9'd1;
            enc_run_code  = enc_run_code + 8'd1;
            // 254 data bytes in a row: close with 0xFF and reserve a new slot
            if (enc_run_code == RUN_FULL) begin
                w[n] = mk_write(enc_code_pos, RUN_FULL, 1'b0, 9'd0, 1'b0);
                n++;
                enc_code_pos  = enc_write_pos;
                enc_write_pos = enc_write_pos + 9'd1;
                enc_run_code  = 8'd1;
            end
        end
        if (eof) begin
            w[n] = mk_write(enc_code_pos, enc_run_code, 1'b0, 9'd0, 1'b0);
            n++;
            w[n] = mk_write(enc_write_pos, DELIM_BYTE, 1'b1, enc_write_pos + 9'd1, 1'b0);
            n++;
            enc_write_pos = 9'd1;
            enc_code_pos  = 9'd0;
            enc_run_code  = 8'd1;
            enc_byte_cnt  = 8'd0;
        end
        w[n-1].run_last = 1'b1;
        if (keep && !enc_paused)
            for (int i = 0; i < n; i++)
                exp_writes.push_back(w[i]);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (err_cnt < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h",
                     $time, what, got, want);
        err_cnt++;
    endtask

    // Sender gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Next frame for the random part. Two long frames of nonzero bytes go in
    // once each, from a fresh frame: one ends on its 254th byte (full run on
    // the final byte), one never sets the end flag and runs past the frame cap.
    function automatic void queue_frame();
        int       kind;
        int       len;
        int       zero_pct;
        in_item_t b;
        kind = $urandom_range(0, 99);
        if (!enc_paused && enc_byte_cnt == 8'd0 && long_done < 2
            && rand_sent >= (long_done == 0 ? 60 : 180)) begin
            len = (long_done == 0) ? 254 : 258;
            for (int i = 0; i < len; i++) begin
                b.data_byte = 8'($urandom_range(1, 255));
                b.last_byte = (long_done == 0) && (i == len - 1);
                frame_q.push_back(b);
            end
            long_left = len;
            long_done++;
        end else if (kind < 15) begin
            // noise: any byte, end flag at random
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                b.data_byte = 8'($urandom_range(0, 255));
                b.last_byte = 1'($urandom_range(0, 1));
                frame_q.push_back(b);
            end
        end else begin
            len      = (kind < 25) ? 1 : $urandom_range(2, 24);
            zero_pct = (kind < 45) ? 50 : 20;
            for (int i = 0; i < len; i++) begin
                b.data_byte = ($urandom_range(0, 99) < zero_pct) ? DELIM_BYTE
                                                                 : 8'($urandom_range(1, 255));
                b.last_byte = (i == len - 1);
                frame_q.push_back(b);
            end
        end
    endfunction

    // Offer one item and hold it until the block takes it. Returns at the
    // accepting edge; the caller's next drive of in_valid lands in that step.
    task automatic send_byte(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering, let every owed write arrive, then stay idle before anything else happens.
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (exp_writes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_pause(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        enc_paused = v;
    endtask

    // Write checker: every accepted write must match the oldest owed one.
    always @(posedge clk) begin : check_writes
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (exp_writes.size() == 0) begin
                flag_mismatch("write with none owed, addr", out_item.write_addr, 0);
            end else begin
                want = exp_writes.pop_front();
                if (out_item.write_addr != want.write_addr)
                    flag_mismatch("write_addr", out_item.write_addr, want.write_addr);
                if (out_item.write_value != want.write_value)
                    flag_mismatch("write_value", out_item.write_value, want.write_value);
                if (out_item.is_delimiter != want.is_delimiter)
                    flag_mismatch("is_delimiter", out_item.is_delimiter, want.is_delimiter);
                if (out_item.frame_length != want.frame_length)
                    flag_mismatch("frame_length", out_item.frame_length, want.frame_length);
                if (out_item.run_last != want.run_last)
                    flag_mismatch("run_last", out_item.run_last, want.run_last);
            end
        end
    end

    // Receiver: free runs, short stalls, the odd long stall, and one long
    // hold-off on request so the block backs up into its input.
    initial begin : receiver_stall
        int r;
        int len;
        out_stall = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 24);
                end else if (r < 90) begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[cobs_frame_encoder_core] ERROR");
        $finish;
    end

    initial begin : stimulus
        in_item_t b;
        int       phase;
        int       n_items;
        bit       want_pause;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        gaps_on   = 1'b1;
        hold_req  = 1'b0;
        err_cnt   = 0;
        rand_sent = 0;
        long_done = 0;
        long_left = 0;

        // encoder state after reset
        enc_write_pos = 9'd1;
        enc_code_pos  = 9'd0;
        enc_run_code  = 8'd1;
        enc_byte_cnt  = 8'd0;
        enc_paused    = 1'b0;

        // Directed rows. The first three start from the reset frame state:
        // lone zero byte, lone 0xFF, and an open frame's first write.
        dir_tab[0]  = mk_typed(8'h00, 1'b1, 3'd3,
                               mk_write(9'd0, 8'h01, 1'b0, 9'd0, 1'b0),
                               mk_write(9'd1, 8'h01, 1'b0, 9'd0, 1'b0),
                               mk_write(9'd2, DELIM_BYTE, 1'b1, 9'd3, 1'b1));
        dir_tab[1]  = mk_typed(8'hFF, 1'b1, 3'd3,
                               mk_write(9'd1, 8'hFF, 1'b0, 9'd0, 1'b0),
                               mk_write(9'd0, 8'h02, 1'b0, 9'd0, 1'b0),
                               mk_write(9'd2, DELIM_BYTE, 1'b1, 9'd3, 1'b1));
        dir_tab[2]  = mk_typed(8'h01, 1'b0, 3'd1,
                               mk_write(9'd1, 8'h01, 1'b0, 9'd0, 1'b1), '0, '0);
        dir_tab[3]  = mk_row(CFG_KEEP,   8'h80, 1'b0);
        dir_tab[4]  = mk_row(CFG_KEEP,   8'h00, 1'b0);
        dir_tab[5]  = mk_row(CFG_KEEP,   8'h00, 1'b0);
        dir_tab[6]  = mk_row(CFG_KEEP,   8'h7F, 1'b1);
        dir_tab[7]  = mk_row(CFG_KEEP,   8'h55, 1'b0);
        dir_tab[8]  = mk_row(CFG_KEEP,   8'hAA, 1'b0);
        dir_tab[9]  = mk_row(CFG_KEEP,   8'h00, 1'b1);     // frame ends on a zero
        // pause mid-frame: the first half of this frame writes nothing
        dir_tab[10] = mk_row(CFG_PAUSE,  8'h12, 1'b0);
        dir_tab[11] = mk_row(CFG_KEEP,   8'h34, 1'b0);
        dir_tab[12] = mk_row(CFG_RESUME, 8'h00, 1'b0);
        dir_tab[13] = mk_row(CFG_KEEP,   8'h56, 1'b1);
        dir_tab[14] = mk_row(CFG_PAUSE,  8'hFE, 1'b1);     // whole frame paused
        dir_tab[15] = mk_row(CFG_RESUME, 8'h00, 1'b0);     // all-zero frame
        dir_tab[16] = mk_row(CFG_KEEP,   8'h00, 1'b0);
        dir_tab[17] = mk_row(CFG_KEEP,   8'h00, 1'b1);
        dir_tab[18] = mk_row(CFG_KEEP,   8'h01, 1'b1);
        dir_tab[19] = mk_row(CFG_KEEP,   8'hFF, 1'b0);
        dir_tab[20] = mk_row(CFG_KEEP,   8'h80, 1'b1);

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_pause(1'b0);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].op != CFG_KEEP) begin
                settle();
                write_pause(dir_tab[i].op == CFG_PAUSE);
            end
            if (dir_tab[i].exp_n != 0) begin
                encode_byte(dir_tab[i].item, 1'b0);
                for (int k = 0; k < dir_tab[i].exp_n; k++)
                    exp_writes.push_back(dir_tab[i].exp[k]);
            end else begin
                encode_byte(dir_tab[i].item, 1'b1);
            end
            send_byte(dir_tab[i].item);
        end

        // Random part in phases; the pause bit changes only between phases,
        // which often falls mid-frame. Phase 1 runs back to back against a
        // long receiver hold-off; phase 2 is paused unless a long frame is open.
        phase = 0;
        while (rand_sent < RAND_ITEMS) begin
            settle();
            want_pause = (phase == 2) || (phase > 3 && $urandom_range(0, 3) == 0);
            // long frames are kept unpaused so their writes get checked
            write_pause(want_pause && long_left == 0);
            gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            if (phase == 1)
                hold_req = 1'b1;
            n_items = (phase == 1) ? 80 : $urandom_range(10, 90);
            for (int i = 0; i < n_items; i++) begin
                if (frame_q.size() == 0)
                    queue_frame();
                b = frame_q.pop_front();
                if (long_left > 0)
                    long_left--;
                encode_byte(b, 1'b1);
                send_byte(b);
                rand_sent++;
            end
            phase++;
        end

        settle();
        if (exp_writes.size() != 0)
            flag_mismatch("writes never seen, count", exp_writes.size(), 0);

        if (err_cnt == 0)
            $display("[cobs_frame_encoder_core] OK");
        else
            $display("[cobs_frame_encoder_core] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cobs_enc_pkg.sv
rtl/cobs_enc_step.sv
rtl/cobs_frame_encoder_core.sv
tb/tb.sv
